FILE: src/rrrf_pkg.sv
// Shared types and codes for the ranging responder retry machine.
package rrrf_pkg;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_ACKED   = 2'd1;
   localparam logic [1:0] ST_PENDING = 2'd2;
   localparam logic [1:0] ST_SENT    = 2'd3;

   localparam logic [1:0] EV_TX_DONE   = 2'd0;
   localparam logic [1:0] EV_RX_FRAME  = 2'd1;
   localparam logic [1:0] EV_RX_FAIL   = 2'd2;
   localparam logic [1:0] EV_TIMER_EXP = 2'd3;

   localparam logic [2:0] FT_REQ = 3'd1;
   localparam logic [2:0] FT_ACK = 3'd4;

   localparam logic [2:0] RA_NONE        = 3'd0;
   localparam logic [2:0] RA_ACK         = 3'd1;
   localparam logic [2:0] RA_DATA        = 3'd2;
   localparam logic [2:0] RA_IDLE_LISTEN = 3'd3;
   localparam logic [2:0] RA_IDLE        = 3'd4;

   localparam logic [1:0] TA_LEAVE   = 2'd0;
   localparam logic [1:0] TA_RESTART = 2'd1;
   localparam logic [1:0] TA_STOP    = 2'd2;

   localparam logic       REG_RETRY_LIMIT  = 1'b0;
   localparam logic       REG_REQUEST_CODE = 1'b1;

   localparam logic [7:0] RETRY_LIMIT_RESET  = 8'd3;
   localparam logic [7:0] REQUEST_CODE_RESET = 8'd56;
   localparam logic [7:0] ATTEMPTS_MAX       = 8'hFF;

   typedef struct packed {
      logic [1:0] stage;
      logic [7:0] attempts;
      logic [7:0] sequence_num;
   } state_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [2:0] frame_type;
      logic [7:0] frame_seq;
      logic [7:0] frame_code;
   } event_type;

   typedef struct packed {
      logic [7:0] retry_limit;
      logic [7:0] request_code;
   } config_type;

   typedef struct packed {
      logic [2:0] radio_action;
      logic [1:0] timer_action;
   } action_type;

endpackage

FILE: src/rrrf_if.sv
// Valid/ready channel interfaces for event beats and result beats.
interface rrrf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [2:0] frame_type;
   logic [7:0] frame_seq;
   logic [7:0] frame_code;

   modport source (output valid, req_type, frame_type, frame_seq, frame_code, input ready);
   modport sink (input valid, req_type, frame_type, frame_seq, frame_code, output ready);
endinterface

interface rrrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] radio_action;
   logic [1:0] timer_action;
   logic [1:0] stage_now;
   logic [7:0] attempts_now;
   logic [7:0] sequence_now;

   modport source (output valid, radio_action, timer_action, stage_now, attempts_now,
                   sequence_now, input ready);
   modport sink (input valid, radio_action, timer_action, stage_now, attempts_now,
                 sequence_now, output ready);
endinterface

FILE: src/rrrf_step.sv
// Event decoder: next state and radio/timer actions for one event beat.
module rrrf_step (
   input  rrrf_pkg::state_type  cur_state,
   input  rrrf_pkg::event_type  evt,
   input  rrrf_pkg::config_type cfg,
   output rrrf_pkg::state_type  next_state,
   output rrrf_pkg::action_type act
);
   import rrrf_pkg::*;

   logic [7:0] attempts_inc;

   assign attempts_inc = (cur_state.attempts != ATTEMPTS_MAX) ?
                         cur_state.attempts + 8'd1 : cur_state.attempts;

   always_comb begin
      next_state       = cur_state;
      act.radio_action = RA_NONE;
      act.timer_action = TA_LEAVE;
      case (evt.req_type)
         EV_TX_DONE: begin
            if (cur_state.stage == ST_ACKED) begin
               act.radio_action = RA_DATA;
               act.timer_action = TA_RESTART;
               next_state.stage = ST_PENDING;
            end else if (cur_state.stage == ST_PENDING) begin
               act.timer_action = TA_RESTART;
               next_state.stage = ST_SENT;
            end
         end
         EV_RX_FRAME: begin
            if (evt.frame_type == FT_ACK && cur_state.stage == ST_SENT) begin
               if (evt.frame_seq == cur_state.sequence_num) begin
                  act.timer_action    = TA_STOP;
                  act.radio_action    = RA_IDLE_LISTEN;
                  next_state.stage    = ST_IDLE;
                  next_state.attempts = '0;
               end
            end else if (evt.frame_type == FT_REQ && cur_state.stage == ST_IDLE &&
                         evt.frame_code == cfg.request_code) begin
               act.radio_action        = RA_ACK;
               act.timer_action        = TA_RESTART;
               next_state.sequence_num = evt.frame_seq;
               next_state.stage        = ST_ACKED;
            end else begin
               act.radio_action = RA_IDLE_LISTEN;
            end
         end
         EV_RX_FAIL: begin
            act.radio_action = RA_IDLE;
         end
         EV_TIMER_EXP: begin
            case (cur_state.stage)
               ST_ACKED: begin
                  act.timer_action = TA_STOP;
                  act.radio_action = RA_IDLE_LISTEN;
                  next_state.stage = ST_IDLE;
               end
               ST_PENDING: begin
                  act.timer_action    = TA_STOP;
                  next_state.stage    = ST_IDLE;
                  next_state.attempts = '0;
               end
               ST_SENT: begin
                  if (attempts_inc < cfg.retry_limit) begin
                     act.radio_action    = RA_DATA;
                     next_state.stage    = ST_PENDING;
                     next_state.attempts = attempts_inc;
                  end else begin
                     act.timer_action        = TA_STOP;
                     next_state.stage        = ST_IDLE;
                     next_state.attempts     = '0;
                     next_state.sequence_num = cur_state.sequence_num + 8'd1;
                  end
               end
               default: begin
                  next_state = cur_state;
               end
            endcase
         end
         default: begin
            next_state = cur_state;
         end
      endcase
   end

endmodule

FILE: src/ranging_responder_retry_fsm.sv
// Top level of the ranging responder retry machine with APB register port.
//
//   channel  | dir | handshake            | payload
//   req_beat | in  | valid/ready          | req_type, frame_type, frame_seq, frame_code
//   rsp_beat | out | valid/ready          | radio_action, timer_action, stage_now,
//            |     |                      | attempts_now, sequence_now
//   csr_*    | in  | APB, pready always 1 | retry_limit @0x0, request_code @0x4
//
// The decoder sits between the accepted beat and the result register, and a
// beat is taken every cycle while the result register is empty or being drained.
// Synchronous reset clears state and valid and reloads the configuration defaults.
// A stalled result holds in place and blocks only further event beats.
module ranging_responder_retry_fsm (
   input  logic        clock,
   input  logic        reset,
   rrrf_req_if.sink    req_beat,
   rrrf_rsp_if.source  rsp_beat,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rrrf_pkg::*;

   state_type  state_ff, state_in;
   config_type cfg_ff, cfg_in;
   action_type act;
   logic       rsp_valid_ff, rsp_valid_in;
   action_type rsp_act_ff, rsp_act_in;
   state_type  rsp_state_ff, rsp_state_in;
   event_type  evt;
   state_type  step_state;
   logic       accept;
   logic       csr_write;
   logic       csr_index;

   assign evt.req_type   = req_beat.req_type;
   assign evt.frame_type = req_beat.frame_type;
   assign evt.frame_seq  = req_beat.frame_seq;
   assign evt.frame_code = req_beat.frame_code;

   rrrf_step u_step (
      .cur_state  (state_ff),
      .evt        (evt),
      .cfg        (cfg_ff),
      .next_state (step_state),
      .act        (act)
   );

   assign req_beat.ready = !rsp_valid_ff || rsp_beat.ready;
   assign accept         = req_beat.valid && req_beat.ready;

   assign state_in     = accept ? step_state : state_ff;
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_beat.ready);
   assign rsp_act_in   = accept ? act : rsp_act_ff;
   assign rsp_state_in = accept ? step_state : rsp_state_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_RETRY_LIMIT:  cfg_in.retry_limit  = csr_pwdata[7:0];
            REG_REQUEST_CODE: cfg_in.request_code = csr_pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_RETRY_LIMIT:  csr_prdata = {24'd0, cfg_ff.retry_limit};
         REG_REQUEST_CODE: csr_prdata = {24'd0, cfg_ff.request_code};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= '0;
         cfg_ff.retry_limit  <= RETRY_LIMIT_RESET;
         cfg_ff.request_code <= REQUEST_CODE_RESET;
         rsp_valid_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_act_ff   <= rsp_act_in;
      rsp_state_ff <= rsp_state_in;
   end

   assign rsp_beat.valid        = rsp_valid_ff;
   assign rsp_beat.radio_action = rsp_act_ff.radio_action;
   assign rsp_beat.timer_action = rsp_act_ff.timer_action;
   assign rsp_beat.stage_now    = rsp_state_ff.stage;
   assign rsp_beat.attempts_now = rsp_state_ff.attempts;
   assign rsp_beat.sequence_now = rsp_state_ff.sequence_num;

`ifndef ASSERT_OFF
   a_accept_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted event beat left no result");

   a_state_held_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(state_ff))
      else $error("state moved without an event beat");

   a_idle_exit: assert property (@(posedge clock) disable iff (reset)
      (accept && state_ff.stage == ST_IDLE) |=>
         (state_ff.stage == ST_IDLE || state_ff.stage == ST_ACKED))
      else $error("idle left for a stage other than request acked");

   a_attempts_stage: assert property (@(posedge clock) disable iff (reset)
      (state_ff.attempts != 8'd0) |->
         (state_ff.stage == ST_PENDING || state_ff.stage == ST_SENT))
      else $error("attempt count live outside the data stages");

   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_state_ff == state_ff))
      else $error("result state differs from stored state");
`endif

endmodule

FILE: verif/tb_ranging_responder_retry_fsm.sv
// Self-checking testbench for the ranging responder retry machine: event and result beats.
module tb_ranging_responder_retry_fsm;
   timeunit 1ns;
   timeprecision 1ps;

   import rrrf_pkg::*;

   typedef struct packed {
      logic [2:0] radio_action;
      logic [1:0] timer_action;
      logic [1:0] stage_now;
      logic [7:0] attempts_now;
      logic [7:0] sequence_now;
   } response_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   rrrf_req_if req_ch ();
   rrrf_rsp_if rsp_ch ();

   ranging_responder_retry_fsm dut (
      .clock       (clock),
      .reset       (reset),
      .req_beat    (req_ch),
      .rsp_beat    (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   event_type    pending_events[$];
   response_type expected_responses[$];
   config_type   csr_shadow;

   logic [1:0]   model_stage;
   logic [7:0]   model_attempts;
   logic [7:0]   model_sequence;

   int unsigned  queued_total;
   int unsigned  checked_total;
   int unsigned  mismatch_count;
   bit           req_taken;
   bit           steady_traffic;
   bit           stall_done;
   int unsigned  stall_left;

   always #1 clock = ~clock;

   function automatic response_type advance_responder(event_type ev);
      response_type r;
      r.radio_action = RA_NONE;
      r.timer_action = TA_LEAVE;
      case (ev.req_type)
         EV_TX_DONE: begin
            if (model_stage == ST_ACKED) begin
               r.radio_action = RA_DATA;
               r.timer_action = TA_RESTART;
               model_stage = ST_PENDING;
            end else if (model_stage == ST_PENDING) begin
               r.timer_action = TA_RESTART;
               model_stage = ST_SENT;
            end
         end
         EV_RX_FRAME: begin
            if (ev.frame_type == FT_ACK && model_stage == ST_SENT) begin
               if (ev.frame_seq == model_sequence) begin
                  r.timer_action = TA_STOP;
                  r.radio_action = RA_IDLE_LISTEN;
                  model_stage = ST_IDLE;
                  model_attempts = 8'd0;
               end
            end else if (ev.frame_type == FT_REQ && model_stage == ST_IDLE
                         && ev.frame_code == csr_shadow.request_code) begin
               r.radio_action = RA_ACK;
               r.timer_action = TA_RESTART;
               model_sequence = ev.frame_seq;
               model_stage = ST_ACKED;
            end else begin
               r.radio_action = RA_IDLE_LISTEN;
            end
         end
         EV_RX_FAIL: begin
            r.radio_action = RA_IDLE;
         end
         default: begin
            if (model_stage == ST_ACKED) begin
               r.timer_action = TA_STOP;
               r.radio_action = RA_IDLE_LISTEN;
               model_stage = ST_IDLE;
            end else if (model_stage == ST_PENDING) begin
               r.timer_action = TA_STOP;
               model_stage = ST_IDLE;
               model_attempts = 8'd0;
            end else if (model_stage == ST_SENT) begin
               if (model_attempts != ATTEMPTS_MAX) begin
                  model_attempts = model_attempts + 8'd1;
               end
               if (model_attempts < csr_shadow.retry_limit) begin
                  r.radio_action = RA_DATA;
                  model_stage = ST_PENDING;
               end else begin
                  r.timer_action = TA_STOP;
                  model_stage = ST_IDLE;
                  model_sequence = model_sequence + 8'd1;
                  model_attempts = 8'd0;
               end
            end
         end
      endcase
      r.stage_now = model_stage;
      r.attempts_now = model_attempts;
      r.sequence_now = model_sequence;
      return r;
   endfunction

   task automatic check_field(input string label, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, label, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : beat_monitor
      event_type    got_event;
      response_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            got_event.req_type = req_ch.req_type;
            got_event.frame_type = req_ch.frame_type;
            got_event.frame_seq = req_ch.frame_seq;
            got_event.frame_code = req_ch.frame_code;
            expected_responses.push_back(advance_responder(got_event));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result beat with nothing expected", $realtime);
               end
            end else begin
               want = expected_responses.pop_front();
               check_field("radio_action", 8'(want.radio_action), 8'(rsp_ch.radio_action));
               check_field("timer_action", 8'(want.timer_action), 8'(rsp_ch.timer_action));
               check_field("stage_now", 8'(want.stage_now), 8'(rsp_ch.stage_now));
               check_field("attempts_now", want.attempts_now, rsp_ch.attempts_now);
               check_field("sequence_now", want.sequence_now, rsp_ch.sequence_now);
            end
            checked_total++;
         end
      end
   end

   always @(negedge clock) begin : req_driver
      event_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_events.size() != 0 && (steady_traffic || $urandom_range(99) >= 16)) begin
            nxt = pending_events.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.req_type <= nxt.req_type;
            req_ch.frame_type <= nxt.frame_type;
            req_ch.frame_seq <= nxt.frame_seq;
            req_ch.frame_code <= nxt.frame_code;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : rsp_throttle
      if (!stall_done && checked_total >= 500) begin
         stall_left = 300;
         stall_done = 1'b1;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady_traffic || ($urandom_range(99) >= 16);
      end
   end

   task automatic queue_event(input logic [1:0] kind, input logic [2:0] ftype,
                              input logic [7:0] fseq, input logic [7:0] fcode);
      event_type ev;
      ev.req_type = kind;
      ev.frame_type = ftype;
      ev.frame_seq = fseq;
      ev.frame_code = fcode;
      pending_events.push_back(ev);
      queued_total++;
   endtask

   task automatic queue_plain(input logic [1:0] kind);
      queue_event(kind, 3'($urandom_range(7)), 8'($urandom_range(255)), 8'($urandom_range(255)));
   endtask

   task automatic queue_noise(input logic [7:0] xseq);
      if ($urandom_range(1) == 0) begin
         queue_plain(EV_RX_FAIL);
      end else begin
         queue_event(EV_RX_FRAME, FT_ACK, xseq ^ 8'($urandom_range(1, 255)),
                     8'($urandom_range(255)));
      end
   endtask

   task automatic queue_exchange(input bit give_up);
      logic [7:0]  xseq;
      int unsigned ending;
      int unsigned lim;
      int unsigned retries;
      xseq = 8'($urandom_range(255));
      lim = 32'(csr_shadow.retry_limit);
      ending = give_up ? 2 : $urandom_range(9);
      queue_event(EV_RX_FRAME, FT_REQ, xseq, csr_shadow.request_code);
      if (ending == 0) begin
         queue_plain(EV_TIMER_EXP);
      end else begin
         queue_plain(EV_TX_DONE);
         if (ending == 1) begin
            queue_plain(EV_TIMER_EXP);
         end else begin
            queue_plain(EV_TX_DONE);
            if (give_up || (ending == 2 && lim <= 8)) begin
               retries = (lim == 0) ? 0 : lim - 1;
            end else begin
               retries = (lim <= 1) ? 0 : $urandom_range(0, (lim - 1 > 4) ? 4 : lim - 1);
            end
            repeat (retries) begin
               if ($urandom_range(99) < 15) begin
                  queue_noise(xseq);
               end
               queue_plain(EV_TIMER_EXP);
               queue_plain(EV_TX_DONE);
            end
            if (give_up || (ending == 2 && lim <= 8)) begin
               queue_plain(EV_TIMER_EXP);
            end else begin
               if ($urandom_range(99) < 20) begin
                  queue_noise(xseq);
               end
               queue_event(EV_RX_FRAME, FT_ACK, xseq, 8'($urandom_range(255)));
            end
         end
      end
   endtask

   task automatic run_traffic(input int unsigned budget);
      int unsigned start;
      start = queued_total;
      queue_exchange(1'b1);
      while (queued_total - start < budget) begin
         if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 3)) begin
               queue_plain(2'($urandom_range(3)));
            end
         end else begin
            queue_exchange(1'b0);
         end
      end
   endtask

   task automatic wait_quiet();
      wait (checked_total >= queued_total);
   endtask

   task automatic write_register(input logic index, input logic [7:0] value);
      logic [31:0] upper;
      upper = $urandom();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= {upper[31:8], value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (index == REG_RETRY_LIMIT) begin
         csr_shadow.retry_limit = value;
      end else begin
         csr_shadow.request_code = value;
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.req_type = '0;
      req_ch.frame_type = '0;
      req_ch.frame_seq = '0;
      req_ch.frame_code = '0;
      rsp_ch.ready = 1'b0;
      csr_shadow.retry_limit = RETRY_LIMIT_RESET;
      csr_shadow.request_code = REQUEST_CODE_RESET;
      model_stage = ST_IDLE;
      model_attempts = 8'd0;
      model_sequence = 8'd0;
      queued_total = 0;
      checked_total = 0;
      mismatch_count = 0;
      req_taken = 1'b0;
      steady_traffic = 1'b0;
      stall_done = 1'b0;
      stall_left = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      queue_event(EV_TX_DONE, 3'd0, 8'd0, 8'd0);
      queue_event(EV_TIMER_EXP, 3'd0, 8'd0, 8'd0);
      queue_event(EV_RX_FAIL, 3'd7, 8'd255, 8'd255);
      queue_event(EV_RX_FRAME, 3'd7, 8'd255, 8'd255);
      queue_event(EV_RX_FRAME, FT_ACK, 8'd0, 8'd0);
      queue_event(EV_RX_FRAME, FT_REQ, 8'd1, REQUEST_CODE_RESET + 8'd1);
      queue_event(EV_RX_FRAME, FT_REQ, 8'd255, REQUEST_CODE_RESET);
      queue_event(EV_RX_FRAME, FT_REQ, 8'd7, REQUEST_CODE_RESET);
      queue_event(EV_TIMER_EXP, 3'd0, 8'd0, 8'd0);
      queue_event(EV_RX_FRAME, FT_REQ, 8'd0, REQUEST_CODE_RESET);
      queue_event(EV_TX_DONE, 3'd0, 8'd0, 8'd0);
      queue_event(EV_TIMER_EXP, 3'd0, 8'd0, 8'd0);
      queue_event(EV_RX_FRAME, FT_REQ, 8'hA5, REQUEST_CODE_RESET);
      queue_event(EV_TX_DONE, 3'd0, 8'd0, 8'd0);
      queue_event(EV_TX_DONE, 3'd0, 8'd0, 8'd0);
      queue_event(EV_RX_FRAME, FT_ACK, 8'h5A, 8'd0);
      queue_event(EV_RX_FAIL, 3'd0, 8'd0, 8'd0);
      queue_event(EV_RX_FRAME, FT_ACK, 8'hA5, 8'd0);
      queue_event(EV_RX_FRAME, FT_REQ, 8'h3C, REQUEST_CODE_RESET);
      queue_event(EV_TX_DONE, 3'd0, 8'd0, 8'd0);
      queue_event(EV_TX_DONE, 3'd0, 8'd0, 8'd0);
      repeat (2) begin
         queue_event(EV_TIMER_EXP, 3'd0, 8'd0, 8'd0);
         queue_event(EV_TX_DONE, 3'd0, 8'd0, 8'd0);
      end
      queue_event(EV_TIMER_EXP, 3'd7, 8'd255, 8'd255);
      wait_quiet();

      write_register(REG_RETRY_LIMIT, 8'd1);
      write_register(REG_REQUEST_CODE, 8'd0);
      run_traffic(200);
      wait_quiet();

      write_register(REG_RETRY_LIMIT, 8'd255);
      write_register(REG_REQUEST_CODE, 8'd255);
      run_traffic(700);
      wait_quiet();

      write_register(REG_RETRY_LIMIT, 8'd0);
      write_register(REG_REQUEST_CODE, 8'hA5);
      run_traffic(200);
      wait_quiet();

      steady_traffic = 1'b1;
      write_register(REG_RETRY_LIMIT, 8'($urandom_range(2, 8)));
      write_register(REG_REQUEST_CODE, 8'($urandom_range(255)));
      run_traffic(250);
      wait_quiet();
      steady_traffic = 1'b0;

      write_register(REG_RETRY_LIMIT, RETRY_LIMIT_RESET);
      write_register(REG_REQUEST_CODE, REQUEST_CODE_RESET);
      run_traffic(300);
      wait_quiet();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_responses.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #200us;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
